### rtl/euclidean_distance_unit_core_defines.svh
// Assertion macros for the euclidean distance unit port checker.
`ifndef EUCLIDEAN_DISTANCE_UNIT_CORE_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_UNIT_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define EDU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define EDU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/edu_pkg.sv
// Shared types and constants of the euclidean distance unit.
package edu_pkg;

   // Lanes, one per coordinate
   localparam int LANE_COUNT = 4;

   // Dimensions register
   localparam int DIMS_WIDTH = 3;
   localparam int DIMS_MIN = 2;
   localparam logic [DIMS_WIDTH-1:0] DIMS_RESET = 3'd4;

   // Load strobes of the two lane stages
   typedef struct packed {
      logic diff;
      logic square;
   } edu_lane_adv_type;

   // Load strobes of the two merge stages
   typedef struct packed {
      logic pair;
      logic total;
   } edu_merge_adv_type;

endpackage

### rtl/edu_lane.sv
// One coordinate lane: difference, magnitude and square, two register stages.
module edu_lane
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  edu_lane_adv_type               adv,
   input  logic                           lane_on,
   input  logic signed [COORD_WIDTH-1:0]  coord_a,
   input  logic signed [COORD_WIDTH-1:0]  coord_b,
   output logic [2*COORD_WIDTH-1:0]       square
);

   logic signed [COORD_WIDTH:0] diff;
   logic [COORD_WIDTH:0]        diff_abs;
   logic [COORD_WIDTH-1:0]      mag_in;
   logic [COORD_WIDTH-1:0]      mag_ff;
   logic [2*COORD_WIDTH-1:0]    sq_in;
   logic [2*COORD_WIDTH-1:0]    sq_ff;

   // Take the difference and its magnitude; a lane past the dimension gives zero
   always_comb begin
      diff     = {coord_a[COORD_WIDTH-1], coord_a} - {coord_b[COORD_WIDTH-1], coord_b};
      diff_abs = diff[COORD_WIDTH] ? (~diff + 1'b1) : diff;
      mag_in   = lane_on ? diff_abs[COORD_WIDTH-1:0] : '0;
   end

   // Square the magnitude
   assign sq_in = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (adv.diff) begin
         mag_ff <= mag_in;
      end
      if (adv.square) begin
         sq_ff <= sq_in;
      end
   end

   assign square = sq_ff;

endmodule

### rtl/edu_merge.sv
// Merging adder tree: sums the four lane squares over two register stages.
module edu_merge
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                    clock,
   input  edu_merge_adv_type                       adv,
   input  logic [LANE_COUNT-1:0][2*COORD_WIDTH-1:0] squares,
   output logic [2*COORD_WIDTH+1:0]                total
);

   localparam int SQ_W = 2 * COORD_WIDTH;

   logic [SQ_W:0]   pair_lo_in;
   logic [SQ_W:0]   pair_hi_in;
   logic [SQ_W:0]   pair_lo_ff;
   logic [SQ_W:0]   pair_hi_ff;
   logic [SQ_W+1:0] total_in;
   logic [SQ_W+1:0] total_ff;

   // Add lanes in pairs, then add the pairs
   assign pair_lo_in = {1'b0, squares[0]} + {1'b0, squares[1]};
   assign pair_hi_in = {1'b0, squares[2]} + {1'b0, squares[3]};
   assign total_in   = {1'b0, pair_lo_ff} + {1'b0, pair_hi_ff};

   always_ff @(posedge clock) begin
      if (adv.pair) begin
         pair_lo_ff <= pair_lo_in;
         pair_hi_ff <= pair_hi_in;
      end
      if (adv.total) begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

### rtl/edu_isqrt.sv
// Pipelined floor square root, one root bit per stage; carries the radicand along.
module edu_isqrt
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic [COORD_WIDTH:0]          load,
   input  logic [2*COORD_WIDTH+1:0]      radicand,
   output logic [COORD_WIDTH:0]          root,
   output logic [2*COORD_WIDTH+1:0]      radicand_out
);

   localparam int ROOT_W = COORD_WIDTH + 1;
   localparam int RAD_W  = 2 * ROOT_W;

   logic [ROOT_W:0]   rem_ff  [ROOT_W-1];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;

      logic [ROOT_W:0]   rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      logic [ROOT_W+2:0] rem_shift;
      logic [ROOT_W+2:0] trial;
      logic [ROOT_W+2:0] rem_diff;
      logic              take;

      // Pick up the previous stage, or start from zero at the first
      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit
      assign rem_shift = {rem_prev, rad_prev[2*B+1 -: 2]};
      assign trial     = (ROOT_W+3)'({root_prev, 2'b01});
      assign rem_diff  = rem_shift - trial;
      assign take      = (rem_shift >= trial);

      always_ff @(posedge clock) begin
         if (load[k]) begin
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
            rad_ff[k]  <= rad_prev;
         end
      end

      // The last stage needs no remainder
      if (k < ROOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (load[k]) begin
               rem_ff[k] <= take ? rem_diff[ROOT_W:0] : rem_shift[ROOT_W:0];
            end
         end
      end
   end

   assign root         = root_ff[ROOT_W-1];
   assign radicand_out = rad_ff[ROOT_W-1];

endmodule

### rtl/euclidean_distance_unit_core.sv
// Euclidean distance unit top level: lanes, merge tree, square root and flow control.
//
// Takes one pair of points per cycle and returns the exact squared distance over the
// first 2, 3 or 4 coordinates together with its floor square root. The pipeline has two
// lane stages (difference, square), two adder stages, then one stage per root bit of the
// square-root pipeline, whose last stage is the output register. Throughput is one item
// per cycle; a stall on the result side holds the pipeline, and empty stages keep filling
// meanwhile. The dimensions register is taken as 2 for values below two and as 4
// above four; write it only while no item is in flight.
module euclidean_distance_unit_core
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // Configuration
   input  logic                                         csr_wr_en,
   input  logic [DIMS_WIDTH-1:0]                        csr_wr_data,
   // Input items
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, COORD_WIDTH bits each, from bit 0 up
   input  logic [8*COORD_WIDTH-1:0]                     req_tdata,
   // Result items
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // distance (COORD_WIDTH+1 bits), squared_distance (2*COORD_WIDTH+2 bits),
   // zero fill to a whole byte, from bit 0 up
   output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0]         rsp_tdata
);

   localparam int ROOT_W = COORD_WIDTH + 1;
   localparam int SUM_W  = 2 * COORD_WIDTH + 2;
   localparam int RSP_W  = ((3 * COORD_WIDTH + 3 + 7) / 8) * 8;
   localparam int NSTAGE = 4 + ROOT_W;

   logic [DIMS_WIDTH-1:0]                    dims_ff;
   logic [DIMS_WIDTH-1:0]                    dims_in;
   logic [NSTAGE-1:0]                        valid_ff;
   logic [NSTAGE-1:0]                        valid_in;
   logic [NSTAGE-1:0]                        stage_load;
   logic [LANE_COUNT-1:0]                    lane_on;
   logic [LANE_COUNT-1:0][2*COORD_WIDTH-1:0] squares;
   logic [SUM_W-1:0]                         total;
   logic [ROOT_W-1:0]                        root;
   logic [SUM_W-1:0]                         squared;
   edu_lane_adv_type                         lane_adv;
   edu_merge_adv_type                        merge_adv;

   // Hold the dimensions register until written
   assign dims_in = csr_wr_en ? csr_wr_data : dims_ff;

   // Enable the first two lanes always, the others as the dimension reaches them
   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         lane_on[i] = (i < DIMS_MIN) || (dims_ff > DIMS_WIDTH'(i));
      end
   end

   // Stage loads when empty or when the stage after it takes its item
   always_comb begin
      stage_load[NSTAGE-1] = !valid_ff[NSTAGE-1] || rsp_tready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
      valid_in = (stage_load & {valid_ff[NSTAGE-2:0], req_tvalid}) |
                 (~stage_load & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= DIMS_RESET;
         valid_ff <= '0;
      end else begin
         dims_ff  <= dims_in;
         valid_ff <= valid_in;
      end
   end

   assign lane_adv  = '{diff: stage_load[0], square: stage_load[1]};
   assign merge_adv = '{pair: stage_load[2], total: stage_load[3]};

   // One lane per coordinate
   for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
      edu_lane #(
         .COORD_WIDTH(COORD_WIDTH)
      ) u_lane (
         .clock   (clock),
         .adv     (lane_adv),
         .lane_on (lane_on[i]),
         .coord_a (req_tdata[i*COORD_WIDTH +: COORD_WIDTH]),
         .coord_b (req_tdata[(i+LANE_COUNT)*COORD_WIDTH +: COORD_WIDTH]),
         .square  (squares[i])
      );
   end

   edu_merge #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_merge (
      .clock   (clock),
      .adv     (merge_adv),
      .squares (squares),
      .total   (total)
   );

   edu_isqrt #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_isqrt (
      .clock        (clock),
      .load         (stage_load[NSTAGE-1:4]),
      .radicand     (total),
      .root         (root),
      .radicand_out (squared)
   );

   // Drive the result item from the last root stage
   assign req_tready = stage_load[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = RSP_W'({squared, root});

endmodule

### rtl/edu_port_checker.sv
// Port-level checker for the euclidean distance unit, bound to the top level.
`include "euclidean_distance_unit_core_defines.svh"

module edu_port_checker
   import edu_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((3*COORD_WIDTH+3+7)/8)*8-1:0]  rsp_tdata
);

   localparam int ROOT_W = COORD_WIDTH + 1;
   localparam int SUM_W  = 2 * COORD_WIDTH + 2;
   localparam int CHK_W  = SUM_W + 2;

   logic [CHK_W-1:0] root_wide;
   logic [CHK_W-1:0] root_sq;
   logic [CHK_W-1:0] next_sq;
   logic [CHK_W-1:0] sum_wide;

   // Bracket the squared distance between the root and the root plus one, squared
   assign root_wide = CHK_W'(rsp_tdata[ROOT_W-1:0]);
   assign sum_wide  = CHK_W'(rsp_tdata[ROOT_W +: SUM_W]);
   assign root_sq   = root_wide * root_wide;
   assign next_sq   = (root_wide + 1'b1) * (root_wide + 1'b1);

   `EDU_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid, "result valid after reset")
   `EDU_ASSERT(a_hold_stalled, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `EDU_ASSERT(a_ready_when_drained, !rsp_tvalid |-> req_tready, "input stalled with output empty")
   `EDU_ASSERT(a_root_floor, rsp_tvalid |-> (root_sq <= sum_wide) && (next_sq > sum_wide), "distance is not the floor root")

endmodule

bind euclidean_distance_unit_core edu_port_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/euclidean_distance_unit_core_tb.sv
// Testbench for the euclidean distance unit: streamed point pairs checked against a predictor.
module euclidean_distance_unit_core_tb
   import edu_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int DIST_W = CW + 1;
   localparam int SQ_W = 2 * CW + 2;
   localparam int RSP_W = ((3 * CW + 3 + 7) / 8) * 8;
   localparam int DIMS_MAX = 4;
   localparam int LATENCY = CW + 5;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 150;

   typedef logic [CW-1:0] coord_type;

   // Point A in the low half, x lowest, as on req_tdata
   typedef struct packed {
      logic [LANE_COUNT-1:0][CW-1:0] b;
      logic [LANE_COUNT-1:0][CW-1:0] a;
   } point_pair_type;

   typedef struct packed {
      logic [SQ_W-1:0]   sq_dist;
      logic [DIST_W-1:0] distance;
   } dist_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [DIMS_WIDTH-1:0] csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [8*CW-1:0]       req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;

   point_pair_type        pending_pairs[$];
   dist_result_type       expected_dists[$];
   logic [DIMS_WIDTH-1:0] dims_shadow = DIMS_RESET;
   logic                  req_took = 1'b0;
   int                    mismatch_count = 0;
   int                    idle_cycles = 0;
   int                    burst_left = 1;
   int                    gap_left = 0;
   rx_mode_type           rx_mode = RX_OPEN;
   int                    rx_left = 0;

   euclidean_distance_unit_core #(
      .COORD_WIDTH(CW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sum the squared differences over the used lanes, then take the floor root bit by bit
   function automatic dist_result_type predict_distance(point_pair_type p,
                                                        logic [DIMS_WIDTH-1:0] dims);
      int unsigned       used;
      longint            diff;
      longint unsigned   total;
      longint unsigned   root;
      longint unsigned   trial;
      dist_result_type   r;
      used = (dims < DIMS_MIN) ? DIMS_MIN : ((dims > DIMS_MAX) ? DIMS_MAX : dims);
      total = 0;
      for (int i = 0; i < used; i++) begin
         diff = longint'($signed(p.a[i])) - longint'($signed(p.b[i]));
         if (diff < 0)
            diff = -diff;
         total += longint'(diff * diff);
      end
      root = 0;
      for (int k = DIST_W - 1; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= total)
            root = trial;
      end
      r.distance = root[DIST_W-1:0];
      r.sq_dist = total[SQ_W-1:0];
      return r;
   endfunction

   function automatic point_pair_type pair_of(int ax, int ay, int az, int aw,
                                              int bx, int by, int bz, int bw);
      point_pair_type p;
      p.a[0] = coord_type'(ax);
      p.a[1] = coord_type'(ay);
      p.a[2] = coord_type'(az);
      p.a[3] = coord_type'(aw);
      p.b[0] = coord_type'(bx);
      p.b[1] = coord_type'(by);
      p.b[2] = coord_type'(bz);
      p.b[3] = coord_type'(bw);
      return p;
   endfunction

   // Favour the extremes and small values, otherwise any pattern
   function automatic coord_type random_coord();
      coord_type v;
      case ($urandom_range(0, 9))
         0: v = {1'b0, {(CW-1){1'b1}}};
         1: v = {1'b1, {(CW-1){1'b0}}};
         2: v = '0;
         3: v = coord_type'(int'($urandom_range(0, 15)) - 8);
         default: v = coord_type'($urandom);
      endcase
      return v;
   endfunction

   // Near pairs give small distances and land on the root boundaries often
   function automatic point_pair_type random_pair();
      point_pair_type p;
      logic           near;
      near = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < LANE_COUNT; i++) begin
         p.a[i] = random_coord();
         if (near)
            p.b[i] = p.a[i] + coord_type'(int'($urandom_range(0, 20)) - 10);
         else
            p.b[i] = random_coord();
      end
      return p;
   endfunction

   // Drain the pipeline, then write the dimensions register
   task automatic apply_dims(int value);
      while (pending_pairs.size() != 0 || expected_dists.size() != 0)
         @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = DIMS_WIDTH'(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
      @(posedge clock);
   endtask

   // Sender: bursts of items with random gaps, hold an item until it is taken
   always @(negedge clock) begin : sender
      logic holding;
      holding = req_tvalid && !req_took;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!holding) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (pending_pairs.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs[0];
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: switch between open, coin-toss and sparse acceptance
   always @(negedge clock) begin : receiver
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         default:   rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Predict on accepted items, check accepted results, track the register
   always @(posedge clock) begin : scoreboard
      dist_result_type want;
      req_took = 1'b0;
      if (reset) begin
         dims_shadow = DIMS_RESET;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_dists.push_back(predict_distance(pending_pairs.pop_front(), dims_shadow));
            req_took = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dists.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_dists.pop_front();
               if (rsp_tdata[DIST_W-1:0] !== want.distance) begin
                  $display("%0t: distance expected %0d actual %0d",
                           $time, want.distance, rsp_tdata[DIST_W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[DIST_W+SQ_W-1:DIST_W] !== want.sq_dist) begin
                  $display("%0t: squared_distance expected %0d actual %0d",
                           $time, want.sq_dist, rsp_tdata[DIST_W+SQ_W-1:DIST_W]);
                  mismatch_count++;
               end
               if (rsp_tdata[RSP_W-1:DIST_W+SQ_W] !== '0) begin
                  $display("%0t: fill bits expected 0 actual %h",
                           $time, rsp_tdata[RSP_W-1:DIST_W+SQ_W]);
                  mismatch_count++;
               end
            end
         end
         if (csr_wr_en)
            dims_shadow = csr_wr_data;
      end
   end

   // Stop the run when nothing moves for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("euclidean_distance_unit_core_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      int dims_plan[10];
      dims_plan = '{2, 3, 0, 7, 1, 5, 6, 4, 3, 2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items at the reset setting of four lanes
      pending_pairs.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768));
      pending_pairs.push_back(pair_of(-32768, -32768, -32768, -32768,
                                      32767, 32767, 32767, 32767));
      pending_pairs.push_back(pair_of(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
      pending_pairs.push_back(pair_of(3, 4, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(1, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(1, 1, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(3, 2, 1, 1, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(2, 2, 2, 2, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(-1, -1, -1, -1, 0, 0, 0, 0));
      pending_pairs.push_back(pair_of(32767, 0, 0, 0, -32768, 0, 0, 0));
      pending_pairs.push_back(pair_of(0, 0, 0, 32767, 0, 0, 0, -32768));
      pending_pairs.push_back(pair_of(0, 0, -32768, 0, 0, 0, 32767, 0));
      pending_pairs.push_back(pair_of(32767, -32768, 32767, -32768,
                                      -32768, 32767, -32768, 32767));
      pending_pairs.push_back(pair_of(100, -200, 300, -400, -100, 200, -300, 400));
      pending_pairs.push_back(pair_of(-5, 7, -9, 11, -5, 7, -9, 11));

      // One phase per register setting, out-of-range settings included
      foreach (dims_plan[n]) begin
         apply_dims(dims_plan[n]);
         pending_pairs.push_back(pair_of(32767, 32767, 32767, 32767,
                                         -32768, -32768, -32768, -32768));
         pending_pairs.push_back(pair_of(0, 0, 32767, -32768, 0, 0, -32768, 32767));
         pending_pairs.push_back(pair_of(7, -9, 0, 0, 0, 0, 0, 0));
         for (int i = 0; i < PHASE_ITEMS; i++)
            pending_pairs.push_back(random_pair());
      end

      // Drain, then allow stray results to show up
      while (pending_pairs.size() != 0 || expected_dists.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("euclidean_distance_unit_core_tb: clean");
      else
         $display("euclidean_distance_unit_core_tb: errors");
      $finish;
   end

endmodule
